@@ rtl/core/ealu_pkg.sv @@
// Shared types and constants for the eight-bit ALU with flags.
// Holds the command codes and the flag struct; depends on nothing.
package ealu_pkg;

  localparam int unsigned CmdW  = 4;
  localparam int unsigned WordW = 16;
  localparam int unsigned ByteW = 8;

  typedef enum logic [CmdW-1:0] {
    CmdAdd   = 4'd0,
    CmdAdc   = 4'd1,
    CmdSub   = 4'd2,
    CmdSbc   = 4'd3,
    CmdAnd   = 4'd4,
    CmdOr    = 4'd5,
    CmdXor   = 4'd6,
    CmdCp    = 4'd7,
    CmdInc   = 4'd8,
    CmdDec   = 4'd9,
    CmdAdd16 = 4'd10,
    CmdInc16 = 4'd11
  } cmd_e;

  // Flag register layout, most significant first: zero, subtract, half-carry, carry.
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  localparam flags_t FlagsReset = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};

endpackage

@@ rtl/core/ealu_exec.sv @@
// Combinational execute logic: result and new flags for one command.
// Depends on ealu_pkg for the command codes and the flag struct.
module ealu_exec (
  input  logic [ealu_pkg::CmdW-1:0]  command_i,
  input  logic [ealu_pkg::WordW-1:0] operand_x_i,
  input  logic [ealu_pkg::WordW-1:0] operand_y_i,
  input  ealu_pkg::flags_t           flags_i,
  output logic [ealu_pkg::WordW-1:0] result_o,
  output ealu_pkg::flags_t           flags_o
);

  logic [7:0]  x8;
  logic [7:0]  y8;
  logic        cin_sel;
  logic        use_cin;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_half;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [16:0] add16_sum;
  logic [12:0] add16_half;
  logic [7:0]  and8;
  logic [7:0]  or8;
  logic [7:0]  xor8;

  assign x8 = operand_x_i[7:0];
  assign y8 = operand_y_i[7:0];

  // Only the carry-using forms fold in the stored carry.
  assign use_cin = (command_i == ealu_pkg::CmdAdc) || (command_i == ealu_pkg::CmdSbc);
  assign cin_sel = use_cin & flags_i.c;

  assign add_sum  = {1'b0, x8} + {1'b0, y8} + {8'b0, cin_sel};
  assign add_half = {1'b0, x8[3:0]} + {1'b0, y8[3:0]} + {4'b0, cin_sel};
  // A borrow shows up as the extra top bit going high.
  assign sub_diff = {1'b0, x8} - {1'b0, y8} - {8'b0, cin_sel};
  assign sub_half = {1'b0, x8[3:0]} - {1'b0, y8[3:0]} - {4'b0, cin_sel};

  assign inc8 = y8 + 8'd1;
  assign dec8 = y8 - 8'd1;

  assign add16_sum  = {1'b0, operand_x_i} + {1'b0, operand_y_i};
  assign add16_half = {1'b0, operand_x_i[11:0]} + {1'b0, operand_y_i[11:0]};

  assign and8 = x8 & y8;
  assign or8  = x8 | y8;
  assign xor8 = x8 ^ y8;

  always_comb begin
    result_o = '0;
    flags_o  = flags_i;
    unique case (command_i)
      ealu_pkg::CmdAdd, ealu_pkg::CmdAdc: begin
        result_o = {8'b0, add_sum[7:0]};
        flags_o  = '{z: (add_sum[7:0] == 8'd0), n: 1'b0, h: add_half[4], c: add_sum[8]};
      end
      ealu_pkg::CmdSub, ealu_pkg::CmdSbc: begin
        result_o = {8'b0, sub_diff[7:0]};
        flags_o  = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1, h: sub_half[4], c: sub_diff[8]};
      end
      ealu_pkg::CmdAnd: begin
        result_o = {8'b0, and8};
        flags_o  = '{z: (and8 == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      ealu_pkg::CmdOr: begin
        result_o = {8'b0, or8};
        flags_o  = '{z: (or8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ealu_pkg::CmdXor: begin
        result_o = {8'b0, xor8};
        flags_o  = '{z: (xor8 == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ealu_pkg::CmdCp: begin
        // Compare sets flags as a subtract but hands back the accumulator.
        result_o = {8'b0, x8};
        flags_o  = '{z: (sub_diff[7:0] == 8'd0), n: 1'b1, h: sub_half[4], c: sub_diff[8]};
      end
      ealu_pkg::CmdInc: begin
        result_o = {8'b0, inc8};
        flags_o  = '{z: (inc8 == 8'd0), n: 1'b0, h: (y8[3:0] == 4'hF), c: flags_i.c};
      end
      ealu_pkg::CmdDec: begin
        result_o = {8'b0, dec8};
        flags_o  = '{z: (dec8 == 8'd0), n: 1'b1, h: (y8[3:0] == 4'h0), c: flags_i.c};
      end
      ealu_pkg::CmdAdd16: begin
        result_o = add16_sum[15:0];
        flags_o  = '{z: flags_i.z, n: 1'b0, h: add16_half[12], c: add16_sum[16]};
      end
      ealu_pkg::CmdInc16: begin
        result_o = operand_y_i + 16'd1;
      end
      default: begin
        // Unused codes give zero and leave the flags alone.
        result_o = '0;
        flags_o  = flags_i;
      end
    endcase
  end

endmodule

@@ rtl/core/eight_bit_alu_with_flags.sv @@
// Top level of the eight-bit ALU with zero, subtract, half-carry and carry flags.
// Depends on ealu_pkg and instantiates ealu_exec.
//
//   Channel   Direction  Handshake                Payload
//   -------   ---------  -----------------------  -------------------------------------
//   in        input      in_valid_i/in_ready_o    command_i, operand_x_i, operand_y_i
//   out       output     out_valid_o/out_ready_i  result_o, zero/subtract/half/carry
//
// Each beat is held in the input register and then moves into the result register,
// which drives result_o and the four flag outputs.
// A new beat is accepted every cycle while the output side keeps taking results;
// the flag register feeds back through the execute logic fast enough for that rate.
// Reset clears the flag register and both valid bits; payload registers are not reset.
// An output stall backs up through the result register into the input register,
// and in_ready_o drops only when both hold a beat that cannot move on.
module eight_bit_alu_with_flags (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ealu_pkg::CmdW-1:0]   command_i,
  input  logic [ealu_pkg::WordW-1:0]  operand_x_i,
  input  logic [ealu_pkg::WordW-1:0]  operand_y_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ealu_pkg::WordW-1:0]  result_o,
  output logic                        zero_flag_o,
  output logic                        subtract_flag_o,
  output logic                        half_carry_flag_o,
  output logic                        carry_flag_o
);

  // Input register stage.
  logic                       in_vld_q;
  logic [ealu_pkg::CmdW-1:0]  cmd_q;
  logic [ealu_pkg::WordW-1:0] opx_q;
  logic [ealu_pkg::WordW-1:0] opy_q;

  // Result register stage.
  logic                       out_vld_q;
  logic [ealu_pkg::WordW-1:0] res_q;
  ealu_pkg::flags_t           out_flags_q;

  // Architectural flag register; it advances once per executed beat, in order.
  ealu_pkg::flags_t           flags_q;
  ealu_pkg::flags_t           flags_d;
  logic [ealu_pkg::WordW-1:0] res_d;

  logic out_free;
  logic exec_fire;
  logic in_fire;

  // The result register can take a new beat when empty or being drained.
  assign out_free  = !out_vld_q || out_ready_i;
  assign exec_fire = in_vld_q && out_free;
  // The input register can take a beat when empty or moving on this cycle.
  assign in_ready_o = !in_vld_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  ealu_exec u_exec (
    .command_i   (cmd_q),
    .operand_x_i (opx_q),
    .operand_y_i (opy_q),
    .flags_i     (flags_q),
    .result_o    (res_d),
    .flags_o     (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      flags_q   <= ealu_pkg::FlagsReset;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (exec_fire) begin
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= command_i;
      opx_q <= operand_x_i;
      opy_q <= operand_y_i;
    end
    if (exec_fire) begin
      res_q       <= res_d;
      out_flags_q <= flags_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign result_o          = res_q;
  assign zero_flag_o       = out_flags_q.z;
  assign subtract_flag_o   = out_flags_q.n;
  assign half_carry_flag_o = out_flags_q.h;
  assign carry_flag_o      = out_flags_q.c;

endmodule

@@ verif/eight_bit_alu_with_flags_test.sv @@
// Self-checking test of the eight-bit ALU with zero, subtract, half-carry and carry flags.
// Depends on ealu_pkg and the eight_bit_alu_with_flags RTL, which instantiates ealu_exec.
module eight_bit_alu_with_flags_test;
  import ealu_pkg::*;

  // The clock period is 4 time units, so there are two units to each half period.
  localparam int unsigned ClkPeriod     = 4;
  localparam int unsigned ResetCycles   = 4;
  // After the last prediction is matched, the drain waits this long for any extra result beat.
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned TimeoutCycles = 200000;
  localparam int unsigned MaxShown      = 40;
  // Command codes above the last defined one have no operation; the block returns zero for them.
  localparam int unsigned FirstUnused   = CmdInc16 + 1;
  localparam int unsigned LastCode      = (1 << CmdW) - 1;

  // One result beat as it is predicted and as it comes out of the block.
  typedef struct packed {
    logic [WordW-1:0] result;
    flags_t           flags;
  } alu_beat_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [CmdW-1:0]   command_i;
  logic [WordW-1:0]  operand_x_i;
  logic [WordW-1:0]  operand_y_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [WordW-1:0]  result_o;
  logic              zero_flag_o;
  logic              subtract_flag_o;
  logic              half_carry_flag_o;
  logic              carry_flag_o;

  // The predicted flag register. It changes in the order in which input beats are taken.
  flags_t    model_flags;
  alu_beat_t pending_results[$];

  // These percentages set the idle rates. The test tasks change them between phases.
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  int unsigned mismatch_count;
  int unsigned sent_beats;
  int unsigned unused_beats;
  int unsigned checked_results;

  eight_bit_alu_with_flags dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .operand_x_i       (operand_x_i),
    .operand_y_i       (operand_y_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_o          (result_o),
    .zero_flag_o       (zero_flag_o),
    .subtract_flag_o   (subtract_flag_o),
    .half_carry_flag_o (half_carry_flag_o),
    .carry_flag_o      (carry_flag_o)
  );

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // This function works out the result and the new flags of one command from the current flags.
  // Eight-bit commands use the low bytes and return a zero-extended result. A borrow appears
  // as the sign bit of a difference that is one bit wider than its operands.
  function automatic alu_beat_t alu_predict(input logic [CmdW-1:0] cmd,
                                            input logic [WordW-1:0] x16,
                                            input logic [WordW-1:0] y16,
                                            input flags_t cur);
    logic [ByteW-1:0] x;
    logic [ByteW-1:0] y;
    logic [ByteW-1:0] res8;
    logic [ByteW:0]   wide8;
    logic [4:0]       nib;
    logic [WordW:0]   wide16;
    logic [12:0]      low12;
    logic             cin;
    alu_beat_t        r;
    x        = x16[ByteW-1:0];
    y        = y16[ByteW-1:0];
    cin      = (cmd == CmdAdc || cmd == CmdSbc) ? cur.c : 1'b0;
    r.result = '0;
    r.flags  = cur;
    case (cmd)
      CmdAdd, CmdAdc: begin
        wide8    = {1'b0, x} + {1'b0, y} + {{ByteW{1'b0}}, cin};
        nib      = {1'b0, x[3:0]} + {1'b0, y[3:0]} + {4'b0, cin};
        res8     = wide8[ByteW-1:0];
        r.result = WordW'(res8);
        r.flags  = {res8 == '0, 1'b0, nib[4], wide8[ByteW]};
      end
      CmdSub, CmdSbc, CmdCp: begin
        wide8    = {1'b0, x} - {1'b0, y} - {{ByteW{1'b0}}, cin};
        nib      = {1'b0, x[3:0]} - {1'b0, y[3:0]} - {4'b0, cin};
        res8     = wide8[ByteW-1:0];
        // A compare sets the flags as a subtract does but returns the accumulator.
        r.result = WordW'((cmd == CmdCp) ? x : res8);
        r.flags  = {res8 == '0, 1'b1, nib[4], wide8[ByteW]};
      end
      CmdAnd: begin
        res8     = x & y;
        r.result = WordW'(res8);
        r.flags  = {res8 == '0, 1'b0, 1'b1, 1'b0};
      end
      CmdOr: begin
        res8     = x | y;
        r.result = WordW'(res8);
        r.flags  = {res8 == '0, 1'b0, 1'b0, 1'b0};
      end
      CmdXor: begin
        res8     = x ^ y;
        r.result = WordW'(res8);
        r.flags  = {res8 == '0, 1'b0, 1'b0, 1'b0};
      end
      CmdInc: begin
        res8     = y + 8'd1;
        r.result = WordW'(res8);
        r.flags  = {res8 == '0, 1'b0, y[3:0] == 4'hF, cur.c};
      end
      CmdDec: begin
        res8     = y - 8'd1;
        r.result = WordW'(res8);
        r.flags  = {res8 == '0, 1'b1, y[3:0] == 4'h0, cur.c};
      end
      CmdAdd16: begin
        wide16   = {1'b0, x16} + {1'b0, y16};
        low12    = {1'b0, x16[11:0]} + {1'b0, y16[11:0]};
        r.result = wide16[WordW-1:0];
        r.flags  = {cur.z, 1'b0, low12[12], wide16[WordW]};
      end
      CmdInc16: r.result = y16 + 16'd1;
      default: ;
    endcase
    return r;
  endfunction

  // This task reports a mismatch on one line and counts it. After a while the lines stop,
  // so that a badly broken block does not flood the log, but the counting goes on.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MaxShown) begin
      $display("mismatch at %0t: %s", $time, what);
    end else if (mismatch_count == MaxShown + 1) begin
      $display("further mismatches are counted but not shown");
    end
  endtask

  // The ready side stalls at random according to stall_pct. Ready is decided on the falling
  // edge, so it is stable at the next rising edge. It stays low while reset is asserted.
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // This process takes each result beat at the rising edge and compares it, field by field,
  // with the oldest pending prediction. Outputs read in the active region hold their
  // values from before the edge, so the order of events at the edge does not matter.
  always @(posedge clk_i) begin
    alu_beat_t got;
    alu_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {result_o, zero_flag_o, subtract_flag_o, half_carry_flag_o, carry_flag_o};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat %h with no prediction pending", got));
      end else begin
        want = pending_results.pop_front();
        checked_results++;
        if (got.result !== want.result) begin
          report_mismatch($sformatf("result %h, expected %h", got.result, want.result));
        end
        if (got.flags.z !== want.flags.z) begin
          report_mismatch($sformatf("zero flag %b, expected %b", got.flags.z, want.flags.z));
        end
        if (got.flags.n !== want.flags.n) begin
          report_mismatch($sformatf("subtract flag %b, expected %b",
                                    got.flags.n, want.flags.n));
        end
        if (got.flags.h !== want.flags.h) begin
          report_mismatch($sformatf("half-carry flag %b, expected %b",
                                    got.flags.h, want.flags.h));
        end
        if (got.flags.c !== want.flags.c) begin
          report_mismatch($sformatf("carry flag %b, expected %b", got.flags.c, want.flags.c));
        end
      end
    end
  end

  // This task sends one beat. It is called at a falling edge and returns at a falling edge.
  // Valid stays high from one beat to the next unless an idle gap comes between them,
  // so valid is never lowered and raised in the same time step.
  task automatic send_beat(input logic [CmdW-1:0] cmd, input logic [WordW-1:0] x,
                           input logic [WordW-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    operand_x_i <= x;
    operand_y_i <= y;
    do @(posedge clk_i); while (!in_ready_o);
    // The beat has been taken, so the prediction moves the model flags on at once.
    pending_results.push_back(alu_predict(cmd, x, y, model_flags));
    model_flags = pending_results[$].flags;
    sent_beats++;
    if (cmd >= FirstUnused) unused_beats++;
    @(negedge clk_i);
  endtask

  // This task lowers valid and waits until every predicted result has come back,
  // and then waits through the settle time, in which any extra result beat would be caught.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // The operands lean toward the byte and nibble boundaries, where the carries change,
  // but half of them are random across all 16 bits.
  function automatic logic [WordW-1:0] pick_operand();
    logic [WordW-1:0] v;
    v = WordW'($urandom());
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      2: v[ByteW-1:0] = '1;
      3: v[3:0] = 4'hF;
      4: v[3:0] = 4'h0;
      default: ;
    endcase
    return v;
  endfunction

  // This test covers the corners of each operation. Each beat relies on the flags left by
  // the one before it: the carry-in of adc and sbc, the carry that inc and dec keep, and
  // the zero flag that add16 keeps. The upper bytes are set on some eight-bit commands
  // to show that only the low byte counts.
  task automatic test_directed_corners();
    send_beat(CmdAdd,   16'h0000, 16'h0000);  // result zero, no carries
    send_beat(CmdAdd,   16'hFFFF, 16'h0001);  // wraps to zero with both carries
    send_beat(CmdAdc,   16'h000F, 16'h0000);  // the carry-in alone makes a half-carry
    send_beat(CmdAdd,   16'h0080, 16'h0080);  // carry with no half-carry
    send_beat(CmdAdc,   16'h00FF, 16'h00FF);  // largest sum with carry-in
    send_beat(CmdSub,   16'h0000, 16'h0001);  // borrow out of both nibble and byte
    send_beat(CmdSbc,   16'h0010, 16'h0000);  // the borrow comes from the carry-in only
    send_beat(CmdSub,   16'h00AB, 16'h00AB);  // equal operands give zero
    send_beat(CmdSbc,   16'hFF00, 16'hFF00);
    send_beat(CmdAnd,   16'hFFFF, 16'hFFFF);
    send_beat(CmdAnd,   16'h00F0, 16'h000F);
    send_beat(CmdOr,    16'h0000, 16'h0000);
    send_beat(CmdOr,    16'h00F0, 16'h000F);
    send_beat(CmdXor,   16'h00FF, 16'h00FF);
    send_beat(CmdXor,   16'h0055, 16'h00AA);
    send_beat(CmdCp,    16'h0010, 16'h0020);  // compare with a borrow
    send_beat(CmdInc,   16'h0000, 16'h00FF);  // wraps to zero and keeps the carry
    send_beat(CmdInc,   16'h1234, 16'h000F);
    send_beat(CmdDec,   16'h0000, 16'h0000);  // wraps to 0xFF with a half borrow
    send_beat(CmdDec,   16'h0000, 16'h0001);
    send_beat(CmdAdd16, 16'hFFFF, 16'h0001);  // 16-bit wrap; the zero flag stays as it was
    send_beat(CmdAdd16, 16'h0FFF, 16'h0001);  // half-carry out of bit 11
    send_beat(CmdInc16, 16'h0000, 16'hFFFF);  // 16-bit wrap with every flag unchanged
    drain_results();
  endtask

  // This test sends each unused code once. The result must be zero and the flags unchanged.
  task automatic test_unused_commands();
    int unsigned code;
    for (code = FirstUnused; code <= LastCode; code++) begin
      send_beat(code[CmdW-1:0], pick_operand(), pick_operand());
    end
    drain_results();
  endtask

  // This test sends random traffic under one mix of idling. About one beat in twenty
  // has an unused code. Those beats are still sent and checked but do not count toward the total.
  task automatic test_random_traffic(input int unsigned src_idle, input int unsigned sink_stall,
                                     input int unsigned beats);
    int unsigned      done;
    logic [CmdW-1:0]  cmd;
    send_idle_pct = src_idle;
    stall_pct     = sink_stall;
    done          = 0;
    while (done < beats) begin
      if ($urandom_range(19) == 0) begin
        cmd = CmdW'($urandom_range(LastCode, FirstUnused));
      end else begin
        cmd = CmdW'($urandom_range(CmdInc16, CmdAdd));
        done++;
      end
      send_beat(cmd, pick_operand(), pick_operand());
    end
    drain_results();
  endtask

  // The test sequence. Every input but out_ready_i is driven from time zero. Reset is asserted
  // once and released on a falling edge.
  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    command_i       = CmdAdd;
    operand_x_i     = '0;
    operand_y_i     = '0;
    model_flags     = FlagsReset;
    send_idle_pct   = 0;
    stall_pct       = 0;
    mismatch_count  = 0;
    sent_beats      = 0;
    unused_beats    = 0;
    checked_results = 0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_corners();
    test_unused_commands();
    test_random_traffic(0, 0, 150);
    test_random_traffic(51, 0, 150);
    test_random_traffic(0, 51, 150);
    test_random_traffic(20, 20, 150);

    $display("covered %0d beats (%0d with unused codes) and checked %0d results",
             sent_beats, unused_beats, checked_results);
    $display("traffic ran with no idling, with sender gaps, with receiver stalls and with both");
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // This is a safety net in case the handshake hangs. The limit is far above the slowest
  // correct run.
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("timeout with %0d results still pending", pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
